>>> sv/fat32cw_pkg.sv
// Package for the FAT32 cluster chain walker: field widths, command, kind,
// status and register index codes, walk phase type and FAT32 constants.
// No dependencies.
package fat32cw_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CLUS_W   = 32;
  localparam int unsigned SECT_W   = 32;
  localparam int unsigned SPC_W    = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // One FAT sector holds 128 four-byte entries
  localparam int unsigned ENTRY_SHIFT = 7;

  localparam logic [CLUS_W-1:0] EOC_MARK  = 32'h0FFF_FFFF;
  localparam logic [CLUS_W-1:0] BAD_ENTRY = 32'hFFFF_FFFF;
  localparam logic [CLUS_W-1:0] FIRST_DATA_CLUSTER = 32'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_DELIVER = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA   = 2'd0,
    KIND_FAT    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_BROKEN    = 3'd2,
    ST_END       = 3'd3,
    ST_TURN      = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPC       = 2'd0,
    REG_DATA_START = 2'd1,
    REG_FAT_START = 2'd2,
    REG_FAT_LEN   = 2'd3
  } reg_idx_t;

  // Walk phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_WAIT_START = 4'b0010,
    PH_STREAM     = 4'b0100,
    PH_WAIT_NEXT  = 4'b1000
  } phase_t;

endpackage

>>> sv/fat32_cluster_chain_walker_unit.sv
// FAT32 cluster chain walker, top level: command decode, walk state and a
// two-register result pipeline. Depends on fat32cw_pkg.
//
// Usage
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   start a chain, advance one sector, or deliver the FAT entry that the
//   walker last requested. Every command yields exactly one result on the
//   output channel (out_valid/out_ready): a data sector read, a FAT sector
//   read with the entry's byte offset, or a status-only report.
//   Configuration is a plain write port (cfg_write_en, cfg_index, cfg_data).
//   The user writes it while no transaction is in flight; it is not enforced.
// Timing
//   The walk state updates at the edge that accepts a command; the result
//   is held in the middle stage and then in the output register. One command
//   per cycle is taken when the receiver keeps up. The data sector address
//   needs a multiply of sectors_per_cluster by the relative cluster, done
//   between the middle stage and the output register.
// Reset and stall
//   rst (synchronous) returns the walk to idle, empties both stages and
//   restores the configuration defaults. When the receiver stalls, the result
//   holds, the middle stage fills, and then in_ready drops until it drains.
module fat32_cluster_chain_walker_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // command channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fat32cw_pkg::CMD_W-1:0]        command,
  input  logic [fat32cw_pkg::CLUS_W-1:0]       start_cluster,
  input  logic [fat32cw_pkg::CLUS_W-1:0]       fat_entry,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fat32cw_pkg::KIND_W-1:0]       kind,
  output logic [fat32cw_pkg::SECT_W-1:0]       sector_address,
  output logic [fat32cw_pkg::OFFSET_W-1:0]     entry_offset,
  output logic [fat32cw_pkg::STATUS_W-1:0]     status,
  // configuration
  input  logic                                 cfg_write_en,
  input  logic [fat32cw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fat32cw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fat32cw_pkg::*;

  // Range check: at least 2 and within the FAT
  function automatic logic in_range(input logic [CLUS_W-1:0] cl,
                                    input logic [SECT_W-1:0] fat_len);
    logic [SECT_W-1:0] fat_sect;
    begin
      fat_sect = SECT_W'(cl >> ENTRY_SHIFT);
      in_range = (cl >= FIRST_DATA_CLUSTER) && (fat_sect < fat_len);
    end
  endfunction

  // Configuration registers
  logic [SPC_W-1:0]  sectors_per_cluster;
  logic [SECT_W-1:0] data_start_sector;
  logic [SECT_W-1:0] fat_start_sector;
  logic [SECT_W-1:0] fat_length_sectors;

  // Walk state
  phase_t            phase, phase_next;
  logic [CLUS_W-1:0] current_cluster, current_cluster_next;
  logic [CLUS_W-1:0] following_cluster, following_cluster_next;
  logic [SPC_W-1:0]  sector_in_cluster, sector_in_cluster_next;

  // Middle stage
  logic              s1_valid;
  kind_t             s1_kind, s1_kind_next;
  status_t           s1_status, s1_status_next;
  logic [SECT_W-1:0] s1_addr, s1_addr_next;
  logic [OFFSET_W-1:0] s1_offset, s1_offset_next;
  logic [CLUS_W-1:0] s1_rel, s1_rel_next;
  logic [SECT_W-1:0] s1_base, s1_base_next;

  // Output stage
  kind_t             out_kind;
  status_t           out_status;
  logic [SECT_W-1:0] out_addr;
  logic [OFFSET_W-1:0] out_offset;

  logic in_fire;
  logic advance;
  logic [SPC_W:0] sector_step;
  logic [SPC_W+CLUS_W-1:0] product;
  logic [SECT_W-1:0] data_addr;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;
  assign sector_step = {1'b0, sector_in_cluster} + (SPC_W+1)'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_cluster <= SPC_W'(1);
      data_start_sector   <= '0;
      fat_start_sector    <= '0;
      fat_length_sectors  <= '0;
    end else if (cfg_write_en) begin
      case (reg_idx_t'(cfg_index))
        REG_SPC:        sectors_per_cluster <= cfg_data[SPC_W-1:0];
        REG_DATA_START: data_start_sector   <= cfg_data[SECT_W-1:0];
        REG_FAT_START:  fat_start_sector    <= cfg_data[SECT_W-1:0];
        REG_FAT_LEN:    fat_length_sectors  <= cfg_data[SECT_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode the command, step the walk and build the partial result
  always_comb begin
    phase_next             = phase;
    current_cluster_next   = current_cluster;
    following_cluster_next = following_cluster;
    sector_in_cluster_next = sector_in_cluster;
    s1_kind_next   = KIND_STATUS;
    s1_status_next = ST_TURN;
    s1_addr_next   = '0;
    s1_offset_next = '0;
    s1_rel_next    = current_cluster - FIRST_DATA_CLUSTER;
    s1_base_next   = data_start_sector;
    case (cmd_t'(command))
      CMD_START: begin
        sector_in_cluster_next = '0;
        current_cluster_next   = start_cluster;
        if (in_range(start_cluster, fat_length_sectors)) begin
          phase_next     = PH_WAIT_START;
          s1_kind_next   = KIND_FAT;
          s1_status_next = ST_OK;
          s1_addr_next   = fat_start_sector + SECT_W'(start_cluster >> ENTRY_SHIFT);
          s1_offset_next = {start_cluster[ENTRY_SHIFT-1:0], 2'b00};
        end else begin
          phase_next     = PH_IDLE;
          s1_status_next = ST_BAD_START;
        end
      end
      CMD_DELIVER: begin
        if (phase == PH_WAIT_START || phase == PH_WAIT_NEXT) begin
          following_cluster_next = fat_entry;
          if (fat_entry == '0 || fat_entry == BAD_ENTRY) begin
            phase_next     = PH_IDLE;
            s1_status_next = ST_BROKEN;
          end else begin
            phase_next             = PH_STREAM;
            sector_in_cluster_next = '0;
            s1_kind_next   = KIND_DATA;
            s1_status_next = ST_OK;
          end
        end
      end
      CMD_ADVANCE: begin
        if (phase == PH_STREAM) begin
          if (sector_step >= {1'b0, sectors_per_cluster}) begin
            // Cluster exhausted: stop at the end mark or follow the chain
            sector_in_cluster_next = '0;
            if (following_cluster == EOC_MARK) begin
              phase_next     = PH_IDLE;
              s1_status_next = ST_END;
            end else begin
              current_cluster_next = following_cluster;
              if (in_range(following_cluster, fat_length_sectors)) begin
                phase_next     = PH_WAIT_NEXT;
                s1_kind_next   = KIND_FAT;
                s1_status_next = ST_OK;
                s1_addr_next   = fat_start_sector +
                                 SECT_W'(following_cluster >> ENTRY_SHIFT);
                s1_offset_next = {following_cluster[ENTRY_SHIFT-1:0], 2'b00};
              end else begin
                phase_next     = PH_IDLE;
                s1_status_next = ST_BROKEN;
              end
            end
          end else begin
            sector_in_cluster_next = sector_step[SPC_W-1:0];
            s1_kind_next   = KIND_DATA;
            s1_status_next = ST_OK;
            s1_base_next   = data_start_sector + SECT_W'(sector_step[SPC_W-1:0]);
          end
        end
      end
      default: ;
    endcase
  end

  // Walk state and middle stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      current_cluster   <= '0;
      following_cluster <= '0;
      sector_in_cluster <= '0;
      s1_valid          <= 1'b0;
    end else begin
      if (in_fire) begin
        phase             <= phase_next;
        current_cluster   <= current_cluster_next;
        following_cluster <= following_cluster_next;
        sector_in_cluster <= sector_in_cluster_next;
        s1_valid          <= 1'b1;
      end else if (advance) begin
        s1_valid          <= 1'b0;
      end
    end
  end

  // Middle stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind   <= s1_kind_next;
      s1_status <= s1_status_next;
      s1_addr   <= s1_addr_next;
      s1_offset <= s1_offset_next;
      s1_rel    <= s1_rel_next;
      s1_base   <= s1_base_next;
    end
  end

  // Data sector address: base plus cluster size times relative cluster
  assign product   = {{CLUS_W{1'b0}}, sectors_per_cluster} * {{SPC_W{1'b0}}, s1_rel};
  assign data_addr = s1_base + product[SECT_W-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_kind   <= s1_kind;
      out_status <= s1_status;
      out_offset <= s1_offset;
      out_addr   <= (s1_kind == KIND_DATA) ? data_addr : s1_addr;
    end
  end

  assign kind           = out_kind;
  assign status         = out_status;
  assign sector_address = out_addr;
  assign entry_offset   = out_offset;

  // Checks on the walk and the result pipeline
  a_status_only_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_STATUS) |-> (out_addr == '0 && out_offset == '0))
    else $error("status-only result carries an address or offset");

  a_request_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_STATUS) |-> (out_status == ST_OK))
    else $error("read request with a non-ok status");

  a_bad_start_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && command == CMD_START && start_cluster < FIRST_DATA_CLUSTER)
      |=> (phase == PH_IDLE))
    else $error("bad start cluster left the walk active");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_kind) && $stable(s1_addr)))
    else $error("middle stage lost a transaction under stall");

  a_turn_no_change: assert property (@(posedge clk) disable iff (rst)
    (in_fire && command == CMD_ADVANCE && phase != PH_STREAM)
      |=> ($stable(phase) && $stable(current_cluster)))
    else $error("out-of-turn advance changed the walk state");

endmodule

>>> test/fat32_cluster_chain_walker_unit_test.sv
// Self-checking testbench for fat32_cluster_chain_walker_unit: a directed table,
// then random chain walks under several register settings, with a predictor.
// Depends on fat32cw_pkg and the walker RTL.
module fat32_cluster_chain_walker_unit_test;
  import fat32cw_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 100000;
  localparam int unsigned CONFIG_SETS    = 8;
  localparam int unsigned ITEMS_PER_SET  = 200;
  localparam int unsigned STALL_AT       = 150;
  localparam int unsigned STALL_CYCLES   = 80;
  localparam int unsigned STEADY_FIRST   = 600;
  localparam int unsigned STEADY_LAST    = 900;
  localparam int unsigned IDLE_PERCENT   = 17;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // One result transaction as the walker reports it
  typedef struct packed {
    kind_t                 kind;
    logic [SECT_W-1:0]     addr;
    logic [OFFSET_W-1:0]   offset;
    status_t               st;
  } request_t;

  localparam request_t PREDICTED = '0;

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

  // Directed stimulus row: a command, or a register write (sel is the index)
  typedef struct {
    row_kind_t           rk;
    logic [1:0]          sel;
    logic [CLUS_W-1:0]   a;
    logic [CLUS_W-1:0]   b;
    bit                  typed;
    request_t            want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [CMD_W-1:0]       command;
  logic [CLUS_W-1:0]      start_cluster;
  logic [CLUS_W-1:0]      fat_entry;
  logic                   out_valid;
  logic                   out_ready;
  logic [KIND_W-1:0]      kind;
  logic [SECT_W-1:0]      sector_address;
  logic [OFFSET_W-1:0]    entry_offset;
  logic [STATUS_W-1:0]    status;
  logic                   cfg_write_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Predictor copy of registers and walk state
  logic [SPC_W-1:0]       cfg_spc;
  logic [SECT_W-1:0]      cfg_data_start;
  logic [SECT_W-1:0]      cfg_fat_start;
  logic [SECT_W-1:0]      cfg_fat_len;
  logic [CLUS_W-1:0]      walk_cluster;
  logic [CLUS_W-1:0]      chain_next;
  logic [SPC_W-1:0]       sector_idx;
  phase_t                 walk_phase;

  request_t               pending_requests[$];
  row_t                   directed_rows[$];

  bit                     steady = 1'b0;
  bit                     stall_asked = 1'b0;
  bit                     stall_done = 1'b0;
  int unsigned            cycle_count = 0;
  int unsigned            mismatches = 0;
  int unsigned            n_checked = 0;
  int unsigned            n_data = 0;
  int unsigned            n_fat = 0;
  int unsigned            n_end = 0;
  int unsigned            n_broken = 0;
  int unsigned            n_turn = 0;

  fat32_cluster_chain_walker_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .start_cluster  (start_cluster),
    .fat_entry      (fat_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .sector_address (sector_address),
    .entry_offset   (entry_offset),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_requests.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic request_t status_only(status_t st);
    request_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.st = st;
    return r;
  endfunction

  function automatic bit cluster_ok(logic [CLUS_W-1:0] cl);
    return cl >= FIRST_DATA_CLUSTER && (cl >> ENTRY_SHIFT) < cfg_fat_len;
  endfunction

  function automatic request_t fat_read(logic [CLUS_W-1:0] cl);
    request_t r;
    r.kind = KIND_FAT;
    r.addr = cfg_fat_start + (cl >> ENTRY_SHIFT);
    r.offset = {cl[ENTRY_SHIFT-1:0], 2'b00};
    r.st = ST_OK;
    return r;
  endfunction

  function automatic request_t data_read();
    request_t r;
    r.kind = KIND_DATA;
    r.addr = cfg_data_start + {24'd0, cfg_spc} * (walk_cluster - FIRST_DATA_CLUSTER)
             + {24'd0, sector_idx};
    r.offset = '0;
    r.st = ST_OK;
    return r;
  endfunction

  // Advance the predicted walk by one command and return the request it causes
  function automatic request_t walk_step(logic [CMD_W-1:0] c, logic [CLUS_W-1:0] sc,
                                         logic [CLUS_W-1:0] fe);
    request_t r;
    logic [8:0] nxt;
    r = status_only(ST_TURN);
    case (c)
      CMD_START: begin
        sector_idx = '0;
        walk_cluster = sc;
        if (!cluster_ok(sc)) begin
          walk_phase = PH_IDLE;
          r = status_only(ST_BAD_START);
        end else begin
          walk_phase = PH_WAIT_START;
          r = fat_read(sc);
        end
      end
      CMD_DELIVER: begin
        if (walk_phase == PH_WAIT_START || walk_phase == PH_WAIT_NEXT) begin
          chain_next = fe;
          if (fe == '0 || fe == BAD_ENTRY) begin
            walk_phase = PH_IDLE;
            r = status_only(ST_BROKEN);
          end else begin
            walk_phase = PH_STREAM;
            sector_idx = '0;
            r = data_read();
          end
        end
      end
      CMD_ADVANCE: begin
        if (walk_phase == PH_STREAM) begin
          nxt = {1'b0, sector_idx} + 9'd1;
          if (nxt >= {1'b0, cfg_spc}) begin
            // cluster exhausted: stop at the end mark or follow the chain
            sector_idx = '0;
            if (chain_next == EOC_MARK) begin
              walk_phase = PH_IDLE;
              r = status_only(ST_END);
            end else begin
              walk_cluster = chain_next;
              if (!cluster_ok(walk_cluster)) begin
                walk_phase = PH_IDLE;
                r = status_only(ST_BROKEN);
              end else begin
                walk_phase = PH_WAIT_NEXT;
                r = fat_read(walk_cluster);
              end
            end
          end else begin
            sector_idx = nxt[SPC_W-1:0];
            r = data_read();
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_row(row_kind_t rk, logic [1:0] sel, logic [CLUS_W-1:0] a,
                         logic [CLUS_W-1:0] b, bit typed, request_t want);
    row_t row;
    row.rk = rk;
    row.sel = sel;
    row.a = a;
    row.b = b;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Offer one command, hold it until taken, then record what it should produce
  task automatic send_command(logic [CMD_W-1:0] c, logic [CLUS_W-1:0] sc,
                              logic [CLUS_W-1:0] fe, bit typed, request_t want);
    request_t got;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    start_cluster <= sc;
    fat_entry <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = walk_step(c, sc, fe);
    pending_requests.push_back(typed ? want : got);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_requests.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_SPC:        cfg_spc = value[SPC_W-1:0];
      REG_DATA_START: cfg_data_start = value;
      REG_FAT_START:  cfg_fat_start = value;
      default:        cfg_fat_len = value;
    endcase
    @(posedge clk);
  endtask

  // Mostly in-range clusters, with the range edges and wild values now and then
  function automatic logic [CLUS_W-1:0] pick_cluster();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (cfg_fat_len == '0 || r == 0) return $urandom;
    if (r == 1 && cfg_fat_len < 32'h0200_0000) return cfg_fat_len << ENTRY_SHIFT;
    if (r == 2 && cfg_fat_len <= 32'h0200_0000) return (cfg_fat_len << ENTRY_SHIFT) - 1;
    if (cfg_fat_len >= 4) return $urandom_range(2, 511);
    return $urandom_range(2, cfg_fat_len * 128 - 1);
  endfunction

  function automatic logic [CLUS_W-1:0] pick_entry();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return BAD_ENTRY;
      2, 3:    return EOC_MARK;
      4:       return $urandom;
      default: return pick_cluster();
    endcase
  endfunction

  // Receiver: random back-pressure outside the steady window, one long hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_asked && !stall_done) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_done = 1'b1;
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    request_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_requests.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d addr %h offset %0d status %0d",
                 $time, kind, sector_address, entry_offset, status);
      end else begin
        want = pending_requests.pop_front();
        n_checked++;
        if (want.kind == KIND_DATA) n_data++;
        if (want.kind == KIND_FAT) n_fat++;
        if (want.st == ST_END) n_end++;
        if (want.st == ST_BROKEN) n_broken++;
        if (want.st == ST_TURN) n_turn++;
        if (kind !== want.kind || sector_address !== want.addr ||
            entry_offset !== want.offset || status !== want.st) begin
          mismatches++;
          $display("%0t: expected kind %0d addr %h offset %0d status %0d",
                   $time, want.kind, want.addr, want.offset, want.st);
          $display("%0t:   actual kind %0d addr %h offset %0d status %0d",
                   $time, kind, sector_address, entry_offset, status);
        end
      end
    end
  end

  initial begin
    logic [CMD_W-1:0]  c;
    logic [CLUS_W-1:0] sc;
    logic [CLUS_W-1:0] fe;
    logic [SPC_W-1:0]  spc;
    logic [SECT_W-1:0] flen;
    int unsigned       item;

    rst = 1'b1;
    in_valid = 1'b0;
    command = '0;
    start_cluster = '0;
    fat_entry = '0;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_spc = 8'd1;
    cfg_data_start = '0;
    cfg_fat_start = '0;
    cfg_fat_len = '0;
    walk_cluster = '0;
    chain_next = '0;
    sector_idx = '0;
    walk_phase = PH_IDLE;

    // Reset defaults: nothing in turn, and no start can pass an empty FAT
    add_row(ROW_CMD, CMD_ADVANCE, 32'd0, 32'd0, 1'b1, status_only(ST_TURN));
    add_row(ROW_CMD, CMD_DELIVER, 32'd0, 32'd5, 1'b1, status_only(ST_TURN));
    add_row(ROW_CMD, CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, status_only(ST_TURN));
    add_row(ROW_CMD, CMD_START, 32'd2, 32'd0, 1'b1, status_only(ST_BAD_START));
    // Extreme bases so that addresses can wrap
    add_row(ROW_CFG, REG_SPC, 32'hFFFF_FF02, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CFG, REG_DATA_START, 32'hFFFF_FFF0, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CFG, REG_FAT_START, 32'hFFFF_FFFF, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CFG, REG_FAT_LEN, 32'hFFFF_FFFF, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_START, 32'd0, 32'd0, 1'b1, status_only(ST_BAD_START));
    add_row(ROW_CMD, CMD_START, 32'd1, 32'd0, 1'b1, status_only(ST_BAD_START));
    add_row(ROW_CMD, CMD_START, 32'hFFFF_FFFF, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_DELIVER, 32'd0, 32'd0, 1'b1, status_only(ST_BROKEN));
    add_row(ROW_CMD, CMD_START, 32'd130, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_DELIVER, 32'd0, BAD_ENTRY, 1'b1, status_only(ST_BROKEN));
    add_row(ROW_CMD, CMD_START, 32'd2, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_ADVANCE, 32'd0, 32'd0, 1'b1, status_only(ST_TURN));
    add_row(ROW_CMD, CMD_DELIVER, 32'd0, 32'd3, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_DELIVER, 32'd0, 32'd7, 1'b1, status_only(ST_TURN));
    add_row(ROW_CMD, CMD_ADVANCE, 32'd0, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_ADVANCE, 32'd0, 32'd0, 1'b0, PREDICTED);
    // Restart while waiting for the next entry, then run to the end mark
    add_row(ROW_CMD, CMD_START, 32'd9, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_DELIVER, 32'd0, EOC_MARK, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_ADVANCE, 32'd0, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_ADVANCE, 32'd0, 32'd0, 1'b1, status_only(ST_END));
    // Chain into a cluster below the data area
    add_row(ROW_CMD, CMD_START, 32'd4, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_DELIVER, 32'd0, 32'd1, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_ADVANCE, 32'd0, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_ADVANCE, 32'd0, 32'd0, 1'b1, status_only(ST_BROKEN));
    // Zero cluster size: the first advance leaves the cluster
    add_row(ROW_CFG, REG_SPC, 32'd0, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_START, 32'd5, 32'd0, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_DELIVER, 32'd0, EOC_MARK, 1'b0, PREDICTED);
    add_row(ROW_CMD, CMD_ADVANCE, 32'd0, 32'd0, 1'b1, status_only(ST_END));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].rk == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].sel, directed_rows[i].a);
      end else begin
        send_command(directed_rows[i].sel, directed_rows[i].a, directed_rows[i].b,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random walks, one register setting per set
    for (int p = 0; p < CONFIG_SETS; p++) begin
      case (p)
        0:       spc = 8'd1;
        1:       spc = 8'd128;
        2:       spc = 8'd0;
        3:       spc = 8'd255;
        default: spc = 8'($urandom_range(1, 8));
      endcase
      case (p)
        2:       flen = 32'hFFFF_FFFF;
        5:       flen = 32'd1;
        7:       flen = 32'd0;
        default: flen = $urandom_range(1, 64);
      endcase
      settle();
      write_reg(REG_SPC, {24'($urandom), spc});
      write_reg(REG_DATA_START, (p % 3 == 0) ? 32'($urandom) :
                                (p % 3 == 1) ? 32'd0 : 32'hFFFF_FFFF);
      write_reg(REG_FAT_START, (p % 3 == 2) ? 32'($urandom) :
                               (p % 3 == 0) ? 32'd0 : 32'hFFFF_FFFF);
      write_reg(REG_FAT_LEN, flen);
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        item = p * ITEMS_PER_SET + i;
        if (item == STALL_AT) stall_asked <= 1'b1;
        steady <= (item >= STEADY_FIRST && item < STEADY_LAST);
        sc = $urandom;
        fe = $urandom;
        if ($urandom_range(0, 99) < 12) begin
          c = 2'($urandom_range(0, 3));
        end else begin
          case (walk_phase)
            PH_IDLE: begin
              c = CMD_START;
              sc = pick_cluster();
            end
            PH_WAIT_START, PH_WAIT_NEXT: begin
              c = CMD_DELIVER;
              fe = pick_entry();
            end
            default: c = CMD_ADVANCE;
          endcase
        end
        send_command(c, sc, fe, 1'b0, PREDICTED);
      end
    end

    settle();
    repeat (6) @(posedge clk);
    $display("Checked %0d results: %0d data reads, %0d FAT reads, %0d chain ends",
             n_checked, n_data, n_fat, n_end);
    $display("  %0d broken chains, %0d out-of-turn commands, %0d mismatches",
             n_broken, n_turn, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/fat32cw_pkg.sv
sv/fat32_cluster_chain_walker_unit.sv
test/fat32_cluster_chain_walker_unit_test.sv
